/* src/rpm_pkg.sv */
// Shared types, codes and constants for the route policy rule matcher.
// Depends on nothing; every other file imports this package.
package rpm_pkg;

   localparam int RULE_DEPTH      = 64;
   localparam int PATH_DEPTH      = 64;
   localparam int COMMUNITY_DEPTH = 64;

   localparam int RULE_AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int RULE_CW = $clog2(RULE_DEPTH + 1);
   localparam int PATH_AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
   localparam int PATH_CW = $clog2(PATH_DEPTH + 1);
   localparam int COMM_AW = (COMMUNITY_DEPTH > 1) ? $clog2(COMMUNITY_DEPTH) : 1;
   localparam int COMM_CW = $clog2(COMMUNITY_DEPTH + 1);
   localparam int SCAN_CW = (PATH_CW > COMM_CW) ? PATH_CW : COMM_CW;

   localparam logic [2:0] OP_ADD_RULE   = 3'd0;
   localparam logic [2:0] OP_CLEAR      = 3'd1;
   localparam logic [2:0] OP_BEGIN      = 3'd2;
   localparam logic [2:0] OP_PATH_ASN   = 3'd3;
   localparam logic [2:0] OP_COMMUNITY  = 3'd4;
   localparam logic [2:0] OP_EVALUATE   = 3'd5;

   localparam logic [4:0] KIND_ANY        = 5'd0;
   localparam logic [4:0] KIND_V4_FIRST   = 5'd1;
   localparam logic [4:0] KIND_V4_LAST    = 5'd5;
   localparam logic [4:0] KIND_V6_FIRST   = 5'd6;
   localparam logic [4:0] KIND_V6_LAST    = 5'd10;
   localparam logic [4:0] KIND_PATH_HAS   = 5'd11;
   localparam logic [4:0] KIND_PATH_NOT   = 5'd12;
   localparam logic [4:0] KIND_ORIGIN_IS  = 5'd13;
   localparam logic [4:0] KIND_ORIGIN_NOT = 5'd14;
   localparam logic [4:0] KIND_COMM_HAS   = 5'd15;
   localparam logic [4:0] KIND_COMM_NOT   = 5'd16;

   localparam logic [2:0] SUB_INCLUDES = 3'd0;
   localparam logic [2:0] SUB_EXACT    = 3'd1;
   localparam logic [2:0] SUB_MORE     = 3'd2;
   localparam logic [2:0] SUB_LESS     = 3'd3;

   localparam logic [7:0] SEQ_TYPE   = 8'd2;
   localparam logic [7:0] MAX_V4_LEN = 8'd32;
   localparam logic [7:0] MAX_V6_LEN = 8'd128;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic        family;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [7:0]  prefix_length;
      logic [4:0]  match_kind;
      logic [31:0] match_value;
      logic [1:0]  decision;
      logic [7:0]  segment_type;
      logic        segment_start;
      logic        attribute_start;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       rule_matched;
      logic [5:0] matched_index;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [7:0]  len;
      logic [31:0] value;
      logic [1:0]  decision;
   } rule_type;

   typedef struct packed {
      logic add;
      logic clear;
      logic begin_route;
      logic path;
      logic comm;
      logic eval_start;
      logic rule_next;
      logic scan_start;
      logic scan_step;
      logic record_match;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic no_rules;
      logic last_rule;
      logic rule_is_scan;
      logic rule_hit;
      logic scan_done;
      logic scan_hit;
   } dp_status_type;

   // Leading-ones mask of a prefix length; lengths above 128 are rejected elsewhere.
   function automatic logic [127:0] prefix_mask(input logic [7:0] len);
      logic [127:0] m;
      if (len == 8'd0) begin
         m = '0;
      end else begin
         m = {128{1'b1}} << (8'd128 - len);
      end
      return m;
   endfunction

endpackage

/* src/rpm_ctrl.sv */
// Sequencer of the route policy rule matcher: decodes items, walks rules.
// Depends on rpm_pkg for the command and status structs and operation codes.
module rpm_ctrl
   import rpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  logic [2:0]    req_op,
   input  dp_status_type st,
   output logic          req_ready,
   output cmd_type       cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RREAD = 3'd1;
   localparam logic [2:0] S_RTEST = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_ADD_RULE: begin
                     cmd.add  = 1'b1;
                     state_in = S_RESP;
                  end
                  OP_CLEAR:     cmd.clear = 1'b1;
                  OP_BEGIN:     cmd.begin_route = 1'b1;
                  OP_PATH_ASN:  cmd.path = 1'b1;
                  OP_COMMUNITY: cmd.comm = 1'b1;
                  OP_EVALUATE: begin
                     cmd.eval_start = 1'b1;
                     state_in = st.no_rules ? S_RESP : S_RREAD;
                  end
                  default: ;
               endcase
            end
         end
         S_RREAD: state_in = S_RTEST;
         S_RTEST: begin
            if (st.rule_is_scan) begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else if (st.rule_hit) begin
               cmd.record_match = 1'b1;
               state_in = S_RESP;
            end else if (st.last_rule) begin
               state_in = S_RESP;
            end else begin
               cmd.rule_next = 1'b1;
               state_in = S_RREAD;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_done) begin
               if (st.scan_hit) begin
                  cmd.record_match = 1'b1;
                  state_in = S_RESP;
               end else if (st.last_rule) begin
                  state_in = S_RESP;
               end else begin
                  cmd.rule_next = 1'b1;
                  state_in = S_RREAD;
               end
            end
         end
         S_RESP: begin
            if (st.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* src/rpm_datapath.sv */
// Datapath of the route policy rule matcher: rule table, element buffers,
// route and origin registers, match logic and the result register. Uses rpm_pkg.
module rpm_datapath
   import rpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req,
   input  cmd_type       cmd,
   input  logic          rsp_ready,
   output dp_status_type st,
   output logic          rsp_valid,
   output rsp_type       rsp
);

   rule_type    rule_mem [RULE_DEPTH];
   logic [31:0] path_mem [PATH_DEPTH];
   logic [31:0] comm_mem [COMMUNITY_DEPTH];

   logic [RULE_CW-1:0] rule_count_ff, rule_count_in;
   logic [PATH_CW-1:0] path_count_ff, path_count_in;
   logic [COMM_CW-1:0] comm_count_ff, comm_count_in;
   logic               dropped_ff, dropped_in;
   logic               cur_found_ff, cur_found_in;
   logic [31:0]        cur_asn_ff, cur_asn_in;
   logic               first_found_ff, first_found_in;
   logic [31:0]        first_asn_ff, first_asn_in;

   logic        route_family_ff;
   logic [63:0] route_hi_ff, route_lo_ff;
   logic [7:0]  route_len_ff;

   logic [RULE_CW-1:0] ridx_ff, ridx_in;
   logic [RULE_CW-1:0] ridx_m1;
   rule_type           rule_rd_ff;
   logic [31:0]        path_rd_ff, comm_rd_ff;

   logic [SCAN_CW-1:0] scan_j_ff, scan_j_in, scan_n;
   logic               scan_pend_ff, scan_pend_in;
   logic               scan_found_ff, scan_found_in;
   logic               scan_is_path;
   logic [31:0]        scan_data;

   logic [1:0] res_verdict_ff;
   logic       res_matched_ff;
   logic [5:0] res_index_ff;
   logic [1:0] res_status_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   logic     table_full;
   rule_type new_rule;

   assign table_full = (rule_count_ff >= RULE_CW'(RULE_DEPTH));
   assign ridx_m1    = ridx_ff - RULE_CW'(1);

   always_comb begin
      new_rule.kind     = req.match_kind;
      new_rule.hi       = req.address_high;
      new_rule.lo       = req.address_low;
      new_rule.len      = req.prefix_length;
      new_rule.value    = req.match_value;
      new_rule.decision = req.decision;
      if (req.match_kind inside {[KIND_V4_FIRST:KIND_V4_LAST]}) begin
         new_rule.hi = {req.address_low[31:0], 32'd0};
         new_rule.lo = '0;
      end
   end

   // Memories: one write port, registered reads.
   always_ff @(posedge clock) begin
      if (cmd.add && !table_full) begin
         rule_mem[rule_count_ff[RULE_AW-1:0]] <= new_rule;
      end
      rule_rd_ff <= rule_mem[ridx_m1[RULE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.path && path_count_ff < PATH_CW'(PATH_DEPTH)) begin
         path_mem[path_count_ff[PATH_AW-1:0]] <= req.match_value;
      end
      path_rd_ff <= path_mem[scan_j_ff[PATH_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.comm && comm_count_ff < COMM_CW'(COMMUNITY_DEPTH)) begin
         comm_mem[comm_count_ff[COMM_AW-1:0]] <= req.match_value;
      end
      comm_rd_ff <= comm_mem[scan_j_ff[COMM_AW-1:0]];
   end

   // Counters, drop flag and origin tracking.
   always_comb begin
      rule_count_in  = rule_count_ff;
      path_count_in  = path_count_ff;
      comm_count_in  = comm_count_ff;
      dropped_in     = dropped_ff;
      cur_found_in   = cur_found_ff;
      cur_asn_in     = cur_asn_ff;
      first_found_in = first_found_ff;
      first_asn_in   = first_asn_ff;
      if (cmd.add && !table_full) begin
         rule_count_in = rule_count_ff + RULE_CW'(1);
      end
      if (cmd.clear) begin
         rule_count_in = '0;
      end
      if (cmd.begin_route) begin
         path_count_in  = '0;
         comm_count_in  = '0;
         dropped_in     = 1'b0;
         cur_found_in   = 1'b0;
         cur_asn_in     = '0;
         first_found_in = 1'b0;
         first_asn_in   = '0;
      end
      if (cmd.path) begin
         if (path_count_ff >= PATH_CW'(PATH_DEPTH)) begin
            dropped_in = 1'b1;
         end else begin
            path_count_in = path_count_ff + PATH_CW'(1);
            if (!first_found_ff) begin
               if (req.attribute_start && cur_found_ff) begin
                  // A new attribute closes one that already has an origin.
                  first_found_in = 1'b1;
                  first_asn_in   = cur_asn_ff;
               end else begin
                  if (req.attribute_start) begin
                     cur_found_in = 1'b0;
                     cur_asn_in   = '0;
                  end
                  if (req.segment_type == SEQ_TYPE) begin
                     cur_found_in = 1'b1;
                     cur_asn_in   = req.match_value;
                  end
               end
            end
         end
      end
      if (cmd.comm) begin
         if (comm_count_ff >= COMM_CW'(COMMUNITY_DEPTH)) begin
            dropped_in = 1'b1;
         end else begin
            comm_count_in = comm_count_ff + COMM_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff   <= '0;
         path_count_ff   <= '0;
         comm_count_ff   <= '0;
         dropped_ff      <= 1'b0;
         cur_found_ff    <= 1'b0;
         cur_asn_ff      <= '0;
         first_found_ff  <= 1'b0;
         first_asn_ff    <= '0;
         route_family_ff <= 1'b0;
         route_hi_ff     <= '0;
         route_lo_ff     <= '0;
         route_len_ff    <= '0;
      end else begin
         rule_count_ff  <= rule_count_in;
         path_count_ff  <= path_count_in;
         comm_count_ff  <= comm_count_in;
         dropped_ff     <= dropped_in;
         cur_found_ff   <= cur_found_in;
         cur_asn_ff     <= cur_asn_in;
         first_found_ff <= first_found_in;
         first_asn_ff   <= first_asn_in;
         if (cmd.begin_route) begin
            route_family_ff <= req.family;
            route_hi_ff     <= req.address_high;
            route_lo_ff     <= req.address_low;
            route_len_ff    <= req.prefix_length;
         end
      end
   end

   // Rule test on the entry read in the previous cycle.
   logic         is_v4, is_v6, origin_found, prefix_hit, rule_hit;
   logic [31:0]  origin_value;
   logic [127:0] rule_addr, route_addr, diff, mask_rule, mask_route;
   logic [7:0]   max_len;
   logic [2:0]   sub;
   logic         cov_rule, cov_route;

   assign is_v4 = rule_rd_ff.kind inside {[KIND_V4_FIRST:KIND_V4_LAST]};
   assign is_v6 = rule_rd_ff.kind inside {[KIND_V6_FIRST:KIND_V6_LAST]};
   assign origin_found = first_found_ff || cur_found_ff;
   assign origin_value = first_found_ff ? first_asn_ff : cur_asn_ff;

   always_comb begin
      rule_addr  = {rule_rd_ff.hi, rule_rd_ff.lo};
      route_addr = is_v4 ? {route_lo_ff[31:0], 96'd0} : {route_hi_ff, route_lo_ff};
      max_len    = is_v4 ? MAX_V4_LEN : MAX_V6_LEN;
      sub        = is_v4 ? 3'(rule_rd_ff.kind - KIND_V4_FIRST)
                         : 3'(rule_rd_ff.kind - KIND_V6_FIRST);
      diff       = rule_addr ^ route_addr;
      mask_rule  = prefix_mask(rule_rd_ff.len);
      mask_route = prefix_mask(route_len_ff);
      cov_rule   = (rule_rd_ff.len <= route_len_ff) && ((diff & mask_rule) == '0);
      cov_route  = (route_len_ff <= rule_rd_ff.len) && ((diff & mask_route) == '0);
      prefix_hit = 1'b0;
      if (rule_rd_ff.len <= max_len && route_len_ff <= max_len) begin
         case (sub)
            SUB_INCLUDES: prefix_hit = cov_rule;
            SUB_EXACT:    prefix_hit = cov_rule && (rule_rd_ff.len == route_len_ff);
            SUB_MORE:     prefix_hit = cov_rule && (route_len_ff > rule_rd_ff.len);
            SUB_LESS:     prefix_hit = cov_route && (route_len_ff < rule_rd_ff.len);
            default:      prefix_hit = cov_route;
         endcase
      end
      case (rule_rd_ff.kind)
         KIND_ANY:        rule_hit = 1'b1;
         KIND_ORIGIN_IS:  rule_hit = origin_found && (origin_value == rule_rd_ff.value);
         KIND_ORIGIN_NOT: rule_hit = origin_found && (origin_value != rule_rd_ff.value);
         default: begin
            if (is_v4) begin
               rule_hit = (route_family_ff == 1'b0) && prefix_hit;
            end else if (is_v6) begin
               rule_hit = (route_family_ff == 1'b1) && prefix_hit;
            end else begin
               rule_hit = 1'b0;
            end
         end
      endcase
   end

   // Buffer scan for contains tests, one element read per cycle.
   assign scan_is_path = (rule_rd_ff.kind == KIND_PATH_HAS) ||
                         (rule_rd_ff.kind == KIND_PATH_NOT);
   assign scan_n    = scan_is_path ? SCAN_CW'(path_count_ff) : SCAN_CW'(comm_count_ff);
   assign scan_data = scan_is_path ? path_rd_ff : comm_rd_ff;

   always_comb begin
      scan_j_in     = scan_j_ff;
      scan_pend_in  = 1'b0;
      scan_found_in = scan_found_ff;
      if (cmd.scan_start) begin
         scan_j_in     = '0;
         scan_found_in = 1'b0;
      end else if (cmd.scan_step) begin
         if (scan_pend_ff && scan_data == rule_rd_ff.value) begin
            scan_found_in = 1'b1;
         end
         if (!scan_found_ff && scan_j_ff < scan_n) begin
            scan_j_in    = scan_j_ff + SCAN_CW'(1);
            scan_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_j_ff     <= '0;
         scan_pend_ff  <= 1'b0;
         scan_found_ff <= 1'b0;
      end else begin
         scan_j_ff     <= scan_j_in;
         scan_pend_ff  <= scan_pend_in;
         scan_found_ff <= scan_found_in;
      end
   end

   // Rule walk index: counts down from the number of stored rules.
   always_comb begin
      ridx_in = ridx_ff;
      if (cmd.eval_start) begin
         ridx_in = rule_count_ff;
      end else if (cmd.rule_next) begin
         ridx_in = ridx_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ridx_ff <= '0;
      end else begin
         ridx_ff <= ridx_in;
      end
   end

   // Result staging and the output register.
   always_ff @(posedge clock) begin
      if (cmd.add) begin
         res_verdict_ff <= '0;
         res_matched_ff <= 1'b0;
         res_index_ff   <= '0;
         res_status_ff  <= table_full ? STATUS_FULL : STATUS_OK;
      end else if (cmd.eval_start) begin
         res_verdict_ff <= req.decision;
         res_matched_ff <= 1'b0;
         res_index_ff   <= '0;
         res_status_ff  <= dropped_ff ? STATUS_DROPPED : STATUS_OK;
      end else if (cmd.record_match) begin
         res_verdict_ff <= rule_rd_ff.decision;
         res_matched_ff <= 1'b1;
         res_index_ff   <= 6'(ridx_m1);
      end
      if (cmd.rsp_load) begin
         rsp_ff.verdict       <= res_verdict_ff;
         rsp_ff.rule_matched  <= res_matched_ff;
         rsp_ff.matched_index <= res_index_ff;
         rsp_ff.status        <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      st.out_free     = !rsp_valid_ff || rsp_ready;
      st.no_rules     = (rule_count_ff == '0);
      st.last_rule    = (ridx_ff == RULE_CW'(1));
      st.rule_is_scan = scan_is_path || (rule_rd_ff.kind == KIND_COMM_HAS) ||
                        (rule_rd_ff.kind == KIND_COMM_NOT);
      st.rule_hit     = rule_hit;
      st.scan_done    = scan_found_ff || (scan_j_ff == scan_n && !scan_pend_ff);
      st.scan_hit     = ((rule_rd_ff.kind == KIND_PATH_HAS) ||
                         (rule_rd_ff.kind == KIND_COMM_HAS)) ? scan_found_ff
                                                             : !scan_found_ff;
   end

   a_rule_count_bound: assert property (@(posedge clock) disable iff (reset)
      rule_count_ff <= RULE_CW'(RULE_DEPTH))
      else $error("rule count exceeds table depth");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");

   a_no_load_over_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> scan_j_ff <= scan_n)
      else $error("scan index ran past element count");

endmodule

/* src/route_policy_rule_matcher_core.sv */
// Top level of the route policy rule matcher core.
// Depends on rpm_pkg, rpm_ctrl and rpm_datapath.
//
//   Channel   Direction  Ports                         Payload
//   request   in         req_valid, req_ready          req_data (req_type)
//   response  out        rsp_valid, rsp_ready          rsp_data (rsp_type)
//
// Clear, begin, path and community items are done in the idle state. An add
// goes on to the response state and may wait there for the result register.
// An evaluate visits rules newest first and, for each contains rule, scans
// the path or community buffer at one element read per cycle.
// Reset is synchronous and active high; the memories hold no reset value.
// A pending response does not block new items; only a new result waits.
module route_policy_rule_matcher_core
   import rpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type       cmd;
   dp_status_type st;
   logic          req_fire;

   // An item is taken only while the sequencer is idle.
   assign req_fire = req_valid && req_ready;

   rpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_op    (req_data.operation),
      .st        (st),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // The datapath holds the rule table, the route and its element buffers,
   // and the result register that faces the response channel.
   rpm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
